/* hw/rtl/tfe_pkg.sv */
package tfe_pkg;

  // Frame framing bytes
  localparam logic [7:0] SyncHi      = 8'hA5;
  localparam logic [7:0] SyncLo      = 8'h5A;
  localparam logic [7:0] TailByte    = 8'hAA;
  localparam logic [7:0] AttType     = 8'hA1;
  localparam logic [7:0] MotType     = 8'hA2;
  localparam logic [7:0] AttLength   = 8'd16;
  localparam logic [7:0] MotLength   = 8'd22;
  localparam logic [7:0] AttSumStart = 8'hB1;
  localparam logic [7:0] MotSumStart = 8'hB8;

  // Record geometry
  localparam int unsigned NumValues = 9;
  localparam int unsigned IdxW      = 5;
  localparam logic [IdxW-1:0] IdxSum    = 5'd3;  // header bytes end here
  localparam logic [IdxW-1:0] IdxFirstV = 5'd4;
  localparam logic [IdxW-1:0] AttSumIdx  = 5'd16;
  localparam logic [IdxW-1:0] MotSumIdx  = 5'd22;
  localparam logic [IdxW-1:0] AttLastIdx = 5'd17;
  localparam logic [IdxW-1:0] MotLastIdx = 5'd23;

  // Frame type codes
  typedef enum logic {
    CMD_ATTITUDE = 1'b0,
    CMD_MOTION   = 1'b1
  } cmd_e;

  // One classified record, words already in sign-magnitude form
  typedef struct packed {
    cmd_e                        cmd;
    logic [NumValues-1:0][15:0]  words;
  } rec_t;

  // Two's complement to 16-bit sign-magnitude; the most negative value wraps to zero
  function automatic logic [15:0] sign_mag(input logic [15:0] raw);
    logic [15:0] mag;
    mag = ~raw + 16'd1;
    if (raw[15]) begin
      return 16'h8000 + mag;
    end
    return raw;
  endfunction

endpackage

/* hw/rtl/tfe_front.sv */
module tfe_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [8:0][15:0]     values_i,
  output logic                 rec_valid_o,
  input  logic                 rec_ready_i,
  output tfe_pkg::rec_t        rec_o
);

  logic          valid_q, valid_d;
  tfe_pkg::rec_t rec_q, rec_d;

  // Stage takes a new record whenever it is empty or its record moves on
  assign in_ready_o = !valid_q || rec_ready_i;

  // Classify and convert every value to sign-magnitude
  always_comb begin
    rec_d.cmd = tfe_pkg::cmd_e'(command_i);
    for (int i = 0; i < tfe_pkg::NumValues; i++) begin
      rec_d.words[i] = tfe_pkg::sign_mag(values_i[i]);
    end
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rec_q <= rec_d;
    end
  end

  assign rec_valid_o = valid_q;
  assign rec_o       = rec_q;

endmodule

/* hw/rtl/tfe_queue.sv */
module tfe_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  tfe_pkg::rec_t  push_rec_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output tfe_pkg::rec_t  pop_rec_o
);

  tfe_pkg::rec_t mem_q [2];
  logic          wptr_q, wptr_d;
  logic          rptr_q, rptr_d;
  logic [1:0]    count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointer and occupancy update
  always_comb begin
    wptr_d  = wptr_q ^ push;
    rptr_d  = rptr_q ^ pop;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_rec_i;
    end
  end

  assign pop_rec_o = mem_q[rptr_q];

endmodule

/* hw/rtl/tfe_back.sv */
module tfe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rec_valid_i,
  output logic           rec_ready_o,
  input  tfe_pkg::rec_t  rec_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     frame_byte_o,
  output logic           last_byte_o
);

  logic [tfe_pkg::IdxW-1:0] idx_q, idx_d;
  logic [7:0]               sum_q, sum_d;
  logic                     out_valid_q, out_valid_d;
  logic [7:0]               out_byte_q;
  logic                     out_last_q;
  logic                     load, is_last, in_values;
  logic [7:0]               byte_sel;
  logic [tfe_pkg::IdxW-1:0] voff;
  logic [3:0]               widx;
  logic [15:0]              word;

  // Byte position decode
  assign is_last   = (rec_i.cmd == tfe_pkg::CMD_MOTION) ? (idx_q == tfe_pkg::MotLastIdx)
                                                        : (idx_q == tfe_pkg::AttLastIdx);
  assign voff      = idx_q - tfe_pkg::IdxFirstV;
  assign widx      = voff[tfe_pkg::IdxW-1:1];
  assign in_values = (idx_q > tfe_pkg::IdxSum) && !is_last &&
                     !((rec_i.cmd == tfe_pkg::CMD_MOTION) ? (idx_q == tfe_pkg::MotSumIdx)
                                                          : (idx_q == tfe_pkg::AttSumIdx));
  assign word      = (widx < 4'(tfe_pkg::NumValues)) ? rec_i.words[widx] : 16'h0000;

  // Output byte select
  always_comb begin
    if (idx_q == 5'd0) begin
      byte_sel = tfe_pkg::SyncHi;
    end else if (idx_q == 5'd1) begin
      byte_sel = tfe_pkg::SyncLo;
    end else if (idx_q == 5'd2) begin
      byte_sel = (rec_i.cmd == tfe_pkg::CMD_MOTION) ? tfe_pkg::MotLength
                                                    : tfe_pkg::AttLength;
    end else if (idx_q == tfe_pkg::IdxSum) begin
      byte_sel = (rec_i.cmd == tfe_pkg::CMD_MOTION) ? tfe_pkg::MotType
                                                    : tfe_pkg::AttType;
    end else if (is_last) begin
      byte_sel = tfe_pkg::TailByte;
    end else if (in_values) begin
      byte_sel = voff[0] ? word[7:0] : word[15:8];
    end else begin
      byte_sel = sum_q;
    end
  end

  // Load a byte when one is queued and the output register is free
  assign load        = rec_valid_i && (!out_valid_q || out_ready_i);
  assign rec_ready_o = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = is_last ? '0 : idx_q + 5'd1;
      if (idx_q == 5'd0) begin
        sum_d = (rec_i.cmd == tfe_pkg::CMD_MOTION) ? tfe_pkg::MotSumStart
                                                   : tfe_pkg::AttSumStart;
      end else if (in_values) begin
        sum_d = sum_q + byte_sel;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (load) begin
      out_byte_q <= byte_sel;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign last_byte_o  = out_last_q;

endmodule

/* hw/rtl/telemetry_frame_encoder.sv */
// A record passes through the front stage register, the queue and the
// output byte register before its first byte shows. Throughput: one frame
// byte per cycle while out_ready_i is high; an attitude frame is 18 bytes
// long and a motion frame 24. The front stage and a two-record queue hold
// up to three records, the one being sent included.
// Reset (rst_ni low, asynchronous) empties all stages; no state is kept
// between records.
module telemetry_frame_encoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         command_i,
  input  logic [15:0]  value_0_i,
  input  logic [15:0]  value_1_i,
  input  logic [15:0]  value_2_i,
  input  logic [15:0]  value_3_i,
  input  logic [15:0]  value_4_i,
  input  logic [15:0]  value_5_i,
  input  logic [15:0]  value_6_i,
  input  logic [15:0]  value_7_i,
  input  logic [15:0]  value_8_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [7:0]   frame_byte_o,
  output logic         last_byte_o
);

  logic [8:0][15:0] values;
  logic             f_valid, f_ready;
  tfe_pkg::rec_t    f_rec;
  logic             q_valid, q_ready;
  tfe_pkg::rec_t    q_rec;

  assign values = {value_8_i, value_7_i, value_6_i, value_5_i, value_4_i,
                   value_3_i, value_2_i, value_1_i, value_0_i};

  tfe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .values_i    (values),
    .rec_valid_o (f_valid),
    .rec_ready_i (f_ready),
    .rec_o       (f_rec)
  );

  tfe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_rec_i   (f_rec),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_rec_o    (q_rec)
  );

  tfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_valid_i  (q_valid),
    .rec_ready_o  (q_ready),
    .rec_i        (q_rec),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

/* hw/rtl/tfe_checker.sv */
module tfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  frame_byte_i,
  input logic        last_byte_i
);

  // Nothing leaves the block while it is held in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni && $past(!rst_ni) |-> !out_valid_i)
    else $error("output valid during reset");

  // A stalled byte stays put until its transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(frame_byte_i) &&
                                    $stable(last_byte_i))
    else $error("stalled output changed");

  // The frame end marker only ever sits on the tail byte
  a_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_byte_i |-> frame_byte_i == tfe_pkg::TailByte)
    else $error("last byte is not the tail");

  // A tail transfer is never directly followed by a stale second tail
  a_after_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && last_byte_i |=> !(out_valid_i && last_byte_i))
    else $error("two tails in a row");

endmodule

bind telemetry_frame_encoder tfe_checker u_tfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .frame_byte_i (frame_byte_o),
  .last_byte_i  (last_byte_o)
);

/* sim/telemetry_frame_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the frame encoder, predicts each frame from the
// accepted record and compares every frame byte as it is transferred.
module telemetry_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        command_i,
  input  logic [15:0] value_0_i,
  input  logic [15:0] value_1_i,
  input  logic [15:0] value_2_i,
  input  logic [15:0] value_3_i,
  input  logic [15:0] value_4_i,
  input  logic [15:0] value_5_i,
  input  logic [15:0] value_6_i,
  input  logic [15:0] value_7_i,
  input  logic [15:0] value_8_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        last_byte_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // Frame bytes still owed by the block, oldest first
  frame_byte_t expected_bytes [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Two's complement to sign-magnitude; the magnitude of -32768 carries into
  // bit 15, which cancels the sign bit and leaves zero
  function automatic logic [15:0] to_sign_mag(input logic [15:0] raw);
    logic [15:0] mag;
    mag = -raw;
    if (raw[15]) begin
      return {~mag[15], mag[14:0]};
    end
    return raw;
  endfunction

  function automatic void queue_byte(input logic [7:0] data, input logic last);
    expected_bytes.push_back(frame_byte_t'{data: data, last: last});
  endfunction

  // Whole frame for one record: header, big-endian words, checksum, tail
  function automatic void encode_frame(input tfe_pkg::cmd_e cmd,
                                       input logic [8:0][15:0] values);
    logic [7:0]  sum;
    logic [15:0] word;
    int          count;
    count = (cmd == tfe_pkg::CMD_MOTION) ? 9 : 6;
    sum   = (cmd == tfe_pkg::CMD_MOTION) ? tfe_pkg::MotSumStart : tfe_pkg::AttSumStart;
    queue_byte(tfe_pkg::SyncHi, 1'b0);
    queue_byte(tfe_pkg::SyncLo, 1'b0);
    queue_byte((cmd == tfe_pkg::CMD_MOTION) ? tfe_pkg::MotLength : tfe_pkg::AttLength, 1'b0);
    queue_byte((cmd == tfe_pkg::CMD_MOTION) ? tfe_pkg::MotType : tfe_pkg::AttType, 1'b0);
    for (int k = 0; k < count; k++) begin
      word = to_sign_mag(values[k]);
      queue_byte(word[15:8], 1'b0);
      queue_byte(word[7:0], 1'b0);
      sum = sum + word[15:8] + word[7:0];
    end
    queue_byte(sum, 1'b0);
    queue_byte(tfe_pkg::TailByte, 1'b1);
  endfunction

  // Compare output transfers, then predict from input transfers
  always @(posedge clk_i) begin
    frame_byte_t head;
    if (!rst_ni) begin
      expected_bytes.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected frame byte: expected none, actual 0x%02h last %0b",
                   $time, frame_byte_i, last_byte_i);
          fail_count_o++;
        end else begin
          head = expected_bytes.pop_front();
          if (frame_byte_i !== head.data) begin
            $display("%0t: frame_byte mismatch: expected 0x%02h, actual 0x%02h",
                     $time, head.data, frame_byte_i);
            fail_count_o++;
          end
          if (last_byte_i !== head.last) begin
            $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                     $time, head.last, last_byte_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        encode_frame(tfe_pkg::cmd_e'(command_i),
                     {value_8_i, value_7_i, value_6_i, value_5_i,
                      value_4_i, value_3_i, value_2_i, value_1_i,
                      value_0_i});
      end
    end
    pending_o = expected_bytes.size();
  end

endmodule

/* sim/tb_telemetry_frame_encoder.sv */
`timescale 1ns / 1ps

module tb_telemetry_frame_encoder;

  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 300;
  localparam int NumRandom  = 128;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [8:0][15:0] values;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  frame_byte;
  logic        last_byte;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          hold_req;
  bit          hold_active;

  telemetry_frame_encoder dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .command_i    (command),
    .value_0_i    (values[0]),
    .value_1_i    (values[1]),
    .value_2_i    (values[2]),
    .value_3_i    (values[3]),
    .value_4_i    (values[4]),
    .value_5_i    (values[5]),
    .value_6_i    (values[6]),
    .value_7_i    (values[7]),
    .value_8_i    (values[8]),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .frame_byte_o (frame_byte),
    .last_byte_o  (last_byte)
  );

  telemetry_frame_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .command_i    (command),
    .value_0_i    (values[0]),
    .value_1_i    (values[1]),
    .value_2_i    (values[2]),
    .value_3_i    (values[3]),
    .value_4_i    (values[4]),
    .value_5_i    (values[5]),
    .value_6_i    (values[6]),
    .value_7_i    (values[7]),
    .value_8_i    (values[8]),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .frame_byte_i (frame_byte),
    .last_byte_i  (last_byte),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Bias towards the extremes of the 16-bit range
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      4:       return 16'h8001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one record from a falling edge and hold it until transferred
  task automatic send_record(input tfe_pkg::cmd_e cmd, input logic [8:0][15:0] vals);
    int gap;
    gap = hold_active ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    values   <= vals;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver: runs of ready and stalls of random length, plus one long hold-off
  initial begin
    int len;
    bit rdy;
    out_ready   = 1'b0;
    hold_active = 1'b0;
    @(negedge clk);
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        rdy         = 1'b0;
        len         = HoldCycles;
      end else begin
        hold_active = 1'b0;
        rdy         = ($urandom_range(0, 9) < 6);
        if (rdy) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
        end else begin
          case ($urandom_range(0, 19))
            0:       len = $urandom_range(30, 60);
            1, 2, 3: len = $urandom_range(4, 12);
            default: len = $urandom_range(1, 3);
          endcase
        end
      end
      out_ready <= rdy;
      repeat (len) @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [15:0]      patterns [10];
    logic [8:0][15:0] vals;
    tfe_pkg::cmd_e    cmd;
    patterns = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                 16'h8001, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00};
    rst_n    = 1'b0;
    in_valid = 1'b0;
    command  = 1'b0;
    values   = '0;
    hold_req = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: uniform records of each pattern for both types; attitude
    // records carry the inverse pattern in the unused values
    foreach (patterns[p]) begin
      for (int k = 0; k < 9; k++) vals[k] = (k < 6) ? patterns[p] : ~patterns[p];
      send_record(tfe_pkg::CMD_ATTITUDE, vals);
      for (int k = 0; k < 9; k++) vals[k] = patterns[p];
      send_record(tfe_pkg::CMD_MOTION, vals);
    end
    // Mixed extremes in one record, checksum wraps several times
    vals = {16'h8000, 16'hFFFF, 16'h7FFF, 16'h8001, 16'h0001,
            16'h0000, 16'hFF00, 16'h00FF, 16'hC000};
    send_record(tfe_pkg::CMD_MOTION, vals);
    send_record(tfe_pkg::CMD_ATTITUDE, vals);

    // Random records; one long receiver hold-off part way through
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 30) hold_req = 1'b1;
      cmd = tfe_pkg::cmd_e'($urandom_range(0, 1));
      for (int k = 0; k < 9; k++) vals[k] = pick_value();
      send_record(cmd, vals);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
